// ----- rtl/core/cbor_pkg.sv -----
// Shared types, codes and float widening functions for the streaming CBOR decoder.
// Depends on nothing; every other file of the block imports it.
package cbor_pkg;

    localparam int LVL_W = 7;

    localparam logic [3:0] K_NONE   = 4'd0;
    localparam logic [3:0] K_UINT   = 4'd1;
    localparam logic [3:0] K_BYTES  = 4'd3;
    localparam logic [3:0] K_TEXT   = 4'd4;
    localparam logic [3:0] K_ARRAY  = 4'd5;
    localparam logic [3:0] K_MAP    = 4'd6;
    localparam logic [3:0] K_KEY    = 4'd7;
    localparam logic [3:0] K_KEYPAY = 4'd10;
    localparam logic [3:0] K_FALSE  = 4'd11;
    localparam logic [3:0] K_FLOAT  = 4'd15;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EOI     = 3'd1;
    localparam logic [2:0] ST_INFO    = 3'd2;
    localparam logic [2:0] ST_KEY     = 3'd3;
    localparam logic [2:0] ST_SIMPLE  = 3'd4;
    localparam logic [2:0] ST_MAJOR   = 3'd5;
    localparam logic [2:0] ST_DEEP    = 3'd6;

    localparam logic [2:0] MAJ_TEXT   = 3'd3;
    localparam logic [2:0] MAJ_TAG    = 3'd6;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [2:0] major;
        logic [4:0] info;
    } in_item_t;

    typedef struct packed {
        logic [3:0]       kind;
        logic [63:0]      value;
        logic [7:0]       pay;
        logic [LVL_W-1:0] lvl;
        logic [LVL_W-1:0] closes;
        logic             done;
        logic [2:0]       status;
    } token_t;

    function automatic logic [63:0] half_to_double(input logic [15:0] h);
        logic [4:0]  e;
        logic [9:0]  m;
        logic [63:0] bits;
        logic [63:0] sh;
        logic [3:0]  p;
        e = h[14:10];
        m = h[9:0];
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) begin
                p = 4'(i);
            end
        end
        sh = 64'(m) << (7'd52 - 7'(p));
        if (e == 5'd0) begin
            if (m == 10'd0) begin
                bits = 64'd0;
            end else begin
                bits = {1'b0, 11'(11'(p) + 11'd999), sh[51:0]};
            end
        end else if (e == 5'd31) begin
            bits = (m == 10'd0) ? 64'h7FF0000000000000 : 64'h7FF8000000000000;
        end else begin
            bits = {1'b0, 11'(11'(e) + 11'd1008), m, 42'd0};
        end
        bits[63] = h[15];
        return bits;
    endfunction

    function automatic logic [63:0] single_to_double(input logic [31:0] u);
        logic [7:0]  e;
        logic [22:0] m;
        logic [63:0] bits;
        logic [63:0] sh;
        logic [4:0]  p;
        e = u[30:23];
        m = u[22:0];
        p = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (m[i]) begin
                p = 5'(i);
            end
        end
        sh = 64'(m) << (7'd52 - 7'(p));
        if (e == 8'd0) begin
            if (m == 23'd0) begin
                bits = 64'd0;
            end else begin
                bits = {1'b0, 11'(11'(p) + 11'd874), sh[51:0]};
            end
        end else if (e == 8'd255) begin
            bits = 64'h7FF0000000000000;
            if (m != 23'd0) begin
                bits = bits | 64'h0008000000000000 | {12'd0, m, 29'd0};
            end
        end else begin
            bits = {1'b0, 11'(11'(e) + 11'd896), m, 29'd0};
        end
        bits[63] = u[31];
        return bits;
    endfunction

endpackage

// ----- rtl/core/cbor_front.sv -----
// Input side: two-beat queue that takes message bytes and splits each head byte.
// Depends on cbor_pkg.
module cbor_front
    import cbor_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output logic       full,
    output logic       item_valid,
    output in_item_t   item,
    input  logic       item_take
);

    in_item_t   buf_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = buf_reg[rd_reg];
    assign do_wr      = push && !full;
    assign do_rd      = item_take && item_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            buf_reg[wr_reg] <= '{data: in_byte, last: is_last,
                                 major: in_byte[7:5], info: in_byte[4:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_reg <= !wr_reg;
            end
            if (do_rd)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= 2'(cnt_reg + 2'(do_wr) - 2'(do_rd));
        end
    end

endmodule

// ----- rtl/core/cbor_outq.sv -----
// Result side: two-beat queue of finished tokens.
// Depends on cbor_pkg.
module cbor_outq
    import cbor_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   tok_push,
    input  token_t tok_in,
    output logic   tok_full,
    input  logic   pop,
    output logic   empty,
    output token_t tok_out
);

    token_t     buf_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign tok_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign tok_out  = buf_reg[rd_reg];
    assign do_wr    = tok_push && !tok_full;
    assign do_rd    = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            buf_reg[wr_reg] <= tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_reg <= !wr_reg;
            end
            if (do_rd)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= 2'(cnt_reg + 2'(do_wr) - 2'(do_rd));
        end
    end

endmodule

// ----- rtl/core/cbor_back.sv -----
// Decode engine: head, argument and payload sequencing plus the container stack.
// Depends on cbor_pkg; the top of the stack sits in registers, the rest in a memory.
module cbor_back
    import cbor_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [5:0] max_depth,
    input  logic       item_valid,
    input  in_item_t   item,
    output logic       item_take,
    input  logic       tok_full,
    output logic       tok_push,
    output token_t     tok
);

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        PH_HEAD, PH_KEY, PH_ARG, PH_PAY, PH_ERR, PH_DONE
    } phase_t;

    typedef enum logic {
        S_RUN, S_POP
    } bstate_t;

    typedef struct packed {
        logic        is_map;
        logic [63:0] cnt;
    } level_t;

    level_t mem [DEPTH];

    bstate_t          bs_reg, bs_next;
    phase_t           ph_reg, ph_next;
    logic [3:0]       pkind_reg, pkind_next;
    logic [3:0]       abl_reg, abl_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      pleft_reg, pleft_next;
    logic [LVL_W-1:0] ptr_reg, ptr_next;
    logic [63:0]      top_cnt_reg, top_cnt_next;
    logic             top_map_reg, top_map_next;
    token_t           tok_reg, tok_next;
    phase_t           entry_reg, entry_next;
    logic             last_reg, last_next;
    level_t           rd_reg;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;

    always_comb
    begin
        token_t      t;
        logic        fin;
        logic        dlv;
        logic [3:0]  dkind;
        logic [63:0] dval;
        logic [63:0] acc_sh;
        logic [63:0] f_cnt;
        logic        f_map;
        logic        complete;
        phase_t      ent;
        logic        lst;

        bs_next      = bs_reg;
        ph_next      = ph_reg;
        pkind_next   = pkind_reg;
        abl_next     = abl_reg;
        acc_next     = acc_reg;
        pleft_next   = pleft_reg;
        ptr_next     = ptr_reg;
        top_cnt_next = top_cnt_reg;
        top_map_next = top_map_reg;
        tok_next     = tok_reg;
        entry_next   = entry_reg;
        last_next    = last_reg;
        item_take    = 1'b0;
        tok_push     = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = AW'(ptr_reg - LVL_W'(2));
        wr_en        = 1'b0;
        wr_addr      = AW'(ptr_reg - LVL_W'(1));
        t            = tok_reg;
        fin          = 1'b0;
        dlv          = 1'b0;
        dkind        = K_NONE;
        dval         = 64'd0;
        acc_sh       = {acc_reg[55:0], item.data};
        f_cnt        = top_cnt_reg;
        f_map        = top_map_reg;
        complete     = 1'b0;
        ent          = entry_reg;
        lst          = last_reg;

        unique case (bs_reg)
            S_RUN:
            begin
                if (item_valid && !tok_full)
                begin
                    item_take = 1'b1;
                    ent       = ph_reg;
                    lst       = item.last;
                    t         = '0;
                    t.lvl     = ptr_reg;
                    unique case (ph_reg)
                        PH_HEAD:
                        begin
                            if ({1'b0, max_depth} < ptr_reg || int'(ptr_reg) >= DEPTH)
                            begin
                                t.status = ST_DEEP;
                                ph_next  = PH_ERR;
                            end
                            else if (item.major == MAJ_TAG)
                            begin
                                t.status = ST_MAJOR;
                                ph_next  = PH_ERR;
                            end
                            else if (item.major == MAJ_SIMPLE)
                            begin
                                if (item.data >= 8'hF4 && item.data <= 8'hF7)
                                begin
                                    dlv   = 1'b1;
                                    dkind = 4'(K_FALSE + 4'(item.data[1:0]));
                                end
                                else if (item.data >= 8'hF9 && item.data <= 8'hFB)
                                begin
                                    pkind_next = K_FLOAT;
                                    abl_next   = 4'd1 << item.data[1:0];
                                    pleft_next = 64'(4'd1 << item.data[1:0]);
                                    acc_next   = 64'd0;
                                    ph_next    = PH_ARG;
                                end
                                else
                                begin
                                    t.status = ST_SIMPLE;
                                    ph_next  = PH_ERR;
                                end
                            end
                            else if (item.info < 5'd24)
                            begin
                                dlv   = 1'b1;
                                dkind = 4'(K_UINT + 4'(item.major));
                                dval  = 64'(item.info);
                            end
                            else if (item.info <= 5'd27)
                            begin
                                pkind_next = 4'(K_UINT + 4'(item.major));
                                abl_next   = 4'd1 << item.info[1:0];
                                acc_next   = 64'd0;
                                ph_next    = PH_ARG;
                            end
                            else
                            begin
                                t.status = ST_INFO;
                                ph_next  = PH_ERR;
                            end
                        end
                        PH_KEY:
                        begin
                            if (item.major != MAJ_TEXT)
                            begin
                                t.status = ST_KEY;
                                ph_next  = PH_ERR;
                            end
                            else if (item.info < 5'd24)
                            begin
                                dlv   = 1'b1;
                                dkind = K_KEY;
                                dval  = 64'(item.info);
                            end
                            else if (item.info <= 5'd27)
                            begin
                                pkind_next = K_KEY;
                                abl_next   = 4'd1 << item.info[1:0];
                                acc_next   = 64'd0;
                                ph_next    = PH_ARG;
                            end
                            else
                            begin
                                t.status = ST_INFO;
                                ph_next  = PH_ERR;
                            end
                        end
                        PH_ARG:
                        begin
                            acc_next = acc_sh;
                            abl_next = 4'(abl_reg - 4'd1);
                            if (abl_reg == 4'd1)
                            begin
                                dlv   = 1'b1;
                                dkind = pkind_reg;
                                dval  = acc_sh;
                                if (pkind_reg == K_FLOAT)
                                begin
                                    pleft_next = 64'd0;
                                    if (pleft_reg[3:0] == 4'd2)
                                    begin
                                        dval = half_to_double(acc_sh[15:0]);
                                    end
                                    else if (pleft_reg[3:0] == 4'd4)
                                    begin
                                        dval = single_to_double(acc_sh[31:0]);
                                    end
                                end
                            end
                        end
                        PH_PAY:
                        begin
                            t.kind     = pkind_reg;
                            t.pay      = item.data;
                            pleft_next = pleft_reg - 64'd1;
                            if (pleft_reg == 64'd1)
                            begin
                                if (pkind_reg == K_KEYPAY)
                                begin
                                    ph_next = PH_HEAD;
                                end
                                else
                                begin
                                    fin = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (dlv)
                    begin
                        t.kind  = dkind;
                        t.value = dval;
                        priority if (dkind == K_BYTES || dkind == K_TEXT)
                        begin
                            if (dval == 64'd0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                pleft_next = dval;
                                pkind_next = 4'(dkind + 4'd5);
                                ph_next    = PH_PAY;
                            end
                        end
                        else if (dkind == K_ARRAY || dkind == K_MAP)
                        begin
                            if (dval == 64'd0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                wr_en        = (ptr_reg != '0);
                                top_cnt_next = dval;
                                top_map_next = (dkind == K_MAP);
                                ptr_next     = LVL_W'(ptr_reg + LVL_W'(1));
                                ph_next      = (dkind == K_MAP) ? PH_KEY : PH_HEAD;
                            end
                        end
                        else if (dkind == K_KEY)
                        begin
                            if (dval == 64'd0)
                            begin
                                ph_next = PH_HEAD;
                            end
                            else
                            begin
                                pleft_next = dval;
                                pkind_next = K_KEYPAY;
                                ph_next    = PH_PAY;
                            end
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    complete = !fin;
                end
            end
            S_POP:
            begin
                fin   = 1'b1;
                f_cnt = rd_reg.cnt;
                f_map = rd_reg.is_map;
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            if (ptr_reg == '0)
            begin
                t.done   = 1'b1;
                ph_next  = PH_DONE;
                complete = 1'b1;
            end
            else if (f_cnt == 64'd1)
            begin
                ptr_next = LVL_W'(ptr_reg - LVL_W'(1));
                t.closes = LVL_W'(t.closes + LVL_W'(1));
                if (ptr_reg == LVL_W'(1))
                begin
                    t.done   = 1'b1;
                    ph_next  = PH_DONE;
                    complete = 1'b1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    bs_next    = S_POP;
                    tok_next   = t;
                    entry_next = ent;
                    last_next  = lst;
                end
            end
            else
            begin
                top_cnt_next = f_cnt - 64'd1;
                top_map_next = f_map;
                ph_next      = f_map ? PH_KEY : PH_HEAD;
                complete     = 1'b1;
            end
        end

        if (complete)
        begin
            bs_next  = S_RUN;
            tok_push = 1'b1;
            if (lst)
            begin
                if (ent != PH_ERR && ent != PH_DONE && t.status == ST_OK
                    && ph_next != PH_DONE)
                begin
                    if (ph_next == PH_HEAD && ({1'b0, max_depth} < ptr_next
                        || int'(ptr_next) >= DEPTH))
                    begin
                        t.status = ST_DEEP;
                    end
                    else
                    begin
                        t.status = ST_EOI;
                    end
                end
                ph_next    = PH_HEAD;
                pkind_next = 4'd0;
                abl_next   = 4'd0;
                acc_next   = 64'd0;
                pleft_next = 64'd0;
                ptr_next   = '0;
            end
        end
        tok = t;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= '{is_map: top_map_reg, cnt: top_cnt_reg};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg      <= S_RUN;
            ph_reg      <= PH_HEAD;
            pkind_reg   <= 4'd0;
            abl_reg     <= 4'd0;
            acc_reg     <= 64'd0;
            pleft_reg   <= 64'd0;
            ptr_reg     <= '0;
            top_cnt_reg <= 64'd0;
            top_map_reg <= 1'b0;
            entry_reg   <= PH_HEAD;
            last_reg    <= 1'b0;
        end
        else
        begin
            bs_reg      <= bs_next;
            ph_reg      <= ph_next;
            pkind_reg   <= pkind_next;
            abl_reg     <= abl_next;
            acc_reg     <= acc_next;
            pleft_reg   <= pleft_next;
            ptr_reg     <= ptr_next;
            top_cnt_reg <= top_cnt_next;
            top_map_reg <= top_map_next;
            entry_reg   <= entry_next;
            last_reg    <= last_next;
        end
    end

endmodule

// ----- rtl/core/cbor_stream_decoder.sv -----
// Top level of the streaming CBOR decoder: configuration register, input queue,
// decode engine and token queue. Depends on cbor_pkg and the cbor_* modules.
// The decoder takes one message byte per beat and returns one token per byte,
// in order, through queue-style ports on both sides. A token that completes
// containers passes the engine's pop state once per completed container that
// sits inside another container, as the enclosing stack entry is read from the
// level memory. A byte is registered in the input queue and its token in the
// token queue before the token reaches the result ports. max_depth is at
// byte address 0 of the register port and must only be written while idle.
module cbor_stream_decoder
    import cbor_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          in_byte,
    input  logic                is_last,
    output logic                empty,
    input  logic                pop,
    output logic [3:0]          token_kind,
    output logic [63:0]         token_value,
    output logic [7:0]          payload_byte,
    output logic [LVL_W-1:0]    nest_level,
    output logic [LVL_W-1:0]    closes,
    output logic                done_res,
    output logic [2:0]          status
);

    logic [5:0] max_depth_reg;
    logic       item_valid;
    in_item_t   item;
    logic       item_take;
    logic       tok_full;
    logic       tok_push;
    token_t     tok_in;
    token_t     tok_out;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {26'd0, max_depth_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_depth_reg <= 6'd63;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            max_depth_reg <= pwdata[5:0];
        end
    end

    cbor_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .full       (full),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    cbor_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_depth  (max_depth_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .tok_full   (tok_full),
        .tok_push   (tok_push),
        .tok        (tok_in)
    );

    cbor_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_push (tok_push),
        .tok_in   (tok_in),
        .tok_full (tok_full),
        .pop      (pop),
        .empty    (empty),
        .tok_out  (tok_out)
    );

    assign token_kind   = tok_out.kind;
    assign token_value  = tok_out.value;
    assign payload_byte = tok_out.pay;
    assign nest_level   = tok_out.lvl;
    assign closes       = tok_out.closes;
    assign done_res     = tok_out.done;
    assign status       = tok_out.status;

endmodule
